// File: hw/rtl/umd_pkg.sv
// Shared types and constants for the 128-bit unsigned multiply/divide unit.
// No dependencies; every other file of the block depends on this package.
package umd_pkg;

    // Fixed widths of the request and response payload halves
    localparam int HALF_BITS = 64;
    localparam int FULL_BITS = 128;

    // Operation codes carried in the request
    typedef enum logic [1:0] {
        MODE_MUL = 2'd0,
        MODE_QUO = 2'd1,
        MODE_REM = 2'd2,
        MODE_RSV = 2'd3
    } t_umd_mode;

    // Sequencer states, one-hot
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MUL   = 5'b00010,
        ST_ALIGN = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_FIN   = 5'b10000
    } t_umd_state;

    // Control for the shared add/subtract unit
    typedef struct packed {
        logic sub;  // 1: x - y, 0: x + y
    } t_umd_alu_ctl;

    typedef logic [HALF_BITS-1:0] t_umd_half;

endpackage

// File: hw/rtl/umd_if.sv
// Request and response channel interfaces for the multiply/divide unit.
// Depends on umd_pkg for the payload types.
interface umd_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    umd_pkg::t_umd_half a_lo;
    umd_pkg::t_umd_half a_hi;
    umd_pkg::t_umd_half b_lo;
    umd_pkg::t_umd_half b_hi;

    modport source (output valid, mode, a_lo, a_hi, b_lo, b_hi, input ready);
    modport sink   (input valid, mode, a_lo, a_hi, b_lo, b_hi, output ready);
endinterface

interface umd_rsp_if;
    logic               valid;
    logic               ready;
    umd_pkg::t_umd_half res_lo;
    umd_pkg::t_umd_half res_hi;
    logic               div_zero;

    modport source (output valid, res_lo, res_hi, div_zero, input ready);
    modport sink   (input valid, res_lo, res_hi, div_zero, output ready);
endinterface

// File: hw/rtl/umd_alu.sv
// Shared add/subtract unit of the multiply/divide sequencer.
// Depends on umd_pkg for the control struct.
module umd_alu #(
    parameter int WORD_BITS = 128
) (
    input  umd_pkg::t_umd_alu_ctl  i_ctl,
    input  logic [WORD_BITS-1:0]   i_x,
    input  logic [WORD_BITS-1:0]   i_y,
    output logic [WORD_BITS-1:0]   o_sum,
    output logic                   o_carry
);
    import umd_pkg::*;

    logic [WORD_BITS-1:0] w_y;
    logic [WORD_BITS:0]   w_full;

    // Add, or subtract by two's complement; carry out means x >= y on subtract
    assign w_y     = i_ctl.sub ? ~i_y : i_y;
    assign w_full  = {1'b0, i_x} + {1'b0, w_y} + {{WORD_BITS{1'b0}}, i_ctl.sub};
    assign o_sum   = w_full[WORD_BITS-1:0];
    assign o_carry = w_full[WORD_BITS];
endmodule

// File: hw/rtl/uint128_mul_div_unit.sv
// Top level of the unsigned multiply/divide unit: sequencer, operand registers
// and output register. Depends on umd_pkg, umd_if and umd_alu.
//
// One request at a time, computed on WORD_BITS-wide words with a single shared
// adder/subtractor. Multiply takes one multiplier bit per cycle, then moves to
// the finish state. Divide first aligns the divisor (shifting it left while it
// does not exceed the dividend and its top bit is clear, at most WORD_BITS-1
// places), then restores one quotient bit per cycle, then moves to the finish
// state. Zero divisor and the reserved mode go straight to the finish state.
// From the finish state the sequencer returns to idle to take the next request;
// the finish state stretches while the output register still holds a response
// that has not been taken. The response sits in an output register, so a new
// request is taken as soon as the sequencer is back in idle, even while the
// previous response has not yet been taken. The adder carry chain of WORD_BITS
// bits sets the clock period.
module uint128_mul_div_unit #(
    parameter int WORD_BITS = 128
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    umd_req_if.sink   i_req,
    umd_rsp_if.source o_rsp
);
    import umd_pkg::*;

    localparam int CNT_W = $clog2(WORD_BITS + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_BITS - 1);

    t_umd_state           r_state, n_state;
    t_umd_mode            r_mode, n_mode;
    logic [WORD_BITS-1:0] r_a, n_a;       // multiplicand, or partial remainder
    logic [WORD_BITS-1:0] r_b, n_b;       // multiplier, or divisor
    logic [WORD_BITS-1:0] r_acc, n_acc;   // product, or quotient
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_dz, n_dz;
    logic                 r_out_valid, n_out_valid;
    logic [FULL_BITS-1:0] r_res, n_res;
    logic                 r_res_dz, n_res_dz;

    t_umd_alu_ctl         w_ctl;
    logic [WORD_BITS-1:0] w_alu_x;
    logic [WORD_BITS-1:0] w_sum;
    logic                 w_carry;
    logic [FULL_BITS-1:0] w_a_in;
    logic [FULL_BITS-1:0] w_b_in;
    logic [WORD_BITS-1:0] w_a_op;
    logic [WORD_BITS-1:0] w_b_op;
    logic                 w_req_acc;
    logic                 w_rsp_acc;
    logic                 w_slot_free;

    // Operands cut to the word width
    assign w_a_in = {i_req.a_hi, i_req.a_lo};
    assign w_b_in = {i_req.b_hi, i_req.b_lo};
    assign w_a_op = w_a_in[WORD_BITS-1:0];
    assign w_b_op = w_b_in[WORD_BITS-1:0];

    assign i_req.ready = (r_state == ST_IDLE);
    assign w_req_acc   = i_req.valid && i_req.ready;
    assign w_rsp_acc   = r_out_valid && o_rsp.ready;
    assign w_slot_free = !r_out_valid || o_rsp.ready;

    // Shared unit: add for multiply steps, subtract for divide compares
    assign w_ctl.sub = (r_state != ST_MUL);
    assign w_alu_x   = (r_state == ST_MUL) ? r_acc : r_a;

    umd_alu #(
        .WORD_BITS (WORD_BITS)
    ) u_alu (
        .i_ctl   (w_ctl),
        .i_x     (w_alu_x),
        .i_y     ((r_state == ST_MUL) ? r_a : r_b),
        .o_sum   (w_sum),
        .o_carry (w_carry)
    );

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_a         = r_a;
        n_b         = r_b;
        n_acc       = r_acc;
        n_cnt       = r_cnt;
        n_dz        = r_dz;
        n_out_valid = w_rsp_acc ? 1'b0 : r_out_valid;
        n_res       = r_res;
        n_res_dz    = r_res_dz;
        case (r_state)
            ST_IDLE: begin
                if (w_req_acc) begin
                    n_mode = t_umd_mode'(i_req.mode);
                    n_a    = w_a_op;
                    n_b    = w_b_op;
                    n_acc  = '0;
                    n_cnt  = '0;
                    n_dz   = 1'b0;
                    case (t_umd_mode'(i_req.mode))
                        MODE_MUL: n_state = ST_MUL;
                        MODE_QUO, MODE_REM: begin
                            if (w_b_op == '0) begin
                                n_dz    = 1'b1;
                                n_a     = '0;
                                n_state = ST_FIN;
                            end else begin
                                n_state = ST_ALIGN;
                            end
                        end
                        default: begin
                            n_a     = '0;
                            n_state = ST_FIN;
                        end
                    endcase
                end
            end
            ST_MUL: begin
                // Add multiplicand on a set multiplier bit, then shift both
                if (r_b[0]) begin
                    n_acc = w_sum;
                end
                n_a   = {r_a[WORD_BITS-2:0], 1'b0};
                n_b   = {1'b0, r_b[WORD_BITS-1:1]};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = ST_FIN;
                end
            end
            ST_ALIGN: begin
                // Shift divisor left while it fits and its top bit is clear
                if (w_carry && !r_b[WORD_BITS-1]) begin
                    n_b   = {r_b[WORD_BITS-2:0], 1'b0};
                    n_cnt = r_cnt + 1'b1;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                // Restore one quotient bit per cycle
                if (w_carry) begin
                    n_a = w_sum;
                end
                n_acc = {r_acc[WORD_BITS-2:0], w_carry};
                n_b   = {1'b0, r_b[WORD_BITS-1:1]};
                if (r_cnt == '0) begin
                    n_state = ST_FIN;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_FIN: begin
                // Hand the result to the output register once it is free
                if (w_slot_free) begin
                    n_res       = (r_mode == MODE_REM) ? FULL_BITS'(r_a) : FULL_BITS'(r_acc);
                    n_res_dz    = r_dz;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_a      <= n_a;
        r_b      <= n_b;
        r_acc    <= n_acc;
        r_cnt    <= n_cnt;
        r_dz     <= n_dz;
        r_res    <= n_res;
        r_res_dz <= n_res_dz;
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.res_lo   = r_res[HALF_BITS-1:0];
    assign o_rsp.res_hi   = r_res[FULL_BITS-1:HALF_BITS];
    assign o_rsp.div_zero = r_res_dz;

    // A taken request always leaves idle on the next cycle
    a_req_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req_acc |=> r_state != ST_IDLE)
        else $error("request accepted but sequencer stayed idle");

    // A divide-by-zero response carries a zero result
    a_dz_zero_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res_dz) |-> r_res == '0)
        else $error("divide-by-zero response with nonzero result");

    // New response appears only from the finish state
    a_rsp_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> $past(r_state == ST_FIN))
        else $error("response raised outside the finish state");

    // Alignment never shifts past the word
    a_align_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ALIGN || r_state == ST_DIV) |-> r_cnt <= CNT_LAST)
        else $error("divisor alignment count out of range");
endmodule
